// ===== design/esrsc_pkg.sv =====
// Shared types and constants for the run-length edit script cost block.
// No dependencies; imported by every module of the block.
`default_nettype none

package esrsc_pkg;

    localparam int OP_W    = 3;
    localparam int SYM_W   = 8;
    localparam int COST_W  = 12;
    localparam int ERR_W   = 3;
    localparam int CNT_W   = 11;
    localparam int STEP_W  = 12;
    localparam int KIND_W  = 2;
    localparam int ENTRY_W = KIND_W + STEP_W;

    localparam int DEF_MAX_SEQ_LEN = 1024;
    localparam int DEF_MAX_RUNS    = 1024;

    localparam logic [STEP_W-1:0] STEP_MAX = '1;
    localparam logic [COST_W-1:0] COST_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    localparam logic [KIND_W-1:0] KIND_REP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INS = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_REP = 3'd0,
        OP_ADD_DEL = 3'd1,
        OP_ADD_INS = 3'd2,
        OP_REMOVE  = 3'd3,
        OP_LOAD_U  = 3'd4,
        OP_LOAD_V  = 3'd5,
        OP_EVAL    = 3'd6,
        OP_CLEAR   = 3'd7
    } op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 3'd0,
        ERR_EMPTY     = 3'd1,
        ERR_RUNS_FULL = 3'd2,
        ERR_SEQ_FULL  = 3'd3,
        ERR_STEP_OVF  = 3'd4
    } err_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_TOP_RD,
        S_TOP_LD,
        S_SUM,
        S_CHECK,
        S_COST_RD,
        S_COST_LD,
        S_COST_STEP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic cap;
        logic exec;
        logic top_rd;
        logic top_ld;
        logic sum_init;
        logic sum_rd;
        logic cost_init;
        logic cost_rd;
        logic cur_ld;
        logic indel;
        logic seq_rd;
        logic res_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_eval;
        logic pop_reload;
        logic ptr_zero;
        logic lens_ok;
        logic cur_rep;
        logic left_zero;
        logic res_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/edit_script_run_stack_cost.sv =====
// Top level of the run-length edit script cost block.
// Depends on esrsc_pkg, esrsc_ctrl and esrsc_dp.
//
// Usage:
//   Requests (op, symbol) enter on req_valid/req_ready; every request gives
//   one result (cost, script_valid, error_code, run_count) on res_valid/res_ready.
//   One request is in work at a time. req_ready is high only while idle.
//   A remove that pops a run below which another remains reloads the new
//   top run from the stack before it completes. Evaluate is bound by the
//   single read port of the run stack, which it walks once to sum the run
//   lengths and, for a valid script, once more to reckon the cost, and by
//   the one-step-per-cycle compare of the two sequence memories.
//   The result sits in an output register, so the next request is taken
//   while res_valid waits on res_ready; a result not yet taken holds off
//   the following one from completing.
//   Reset empties the run stack and both sequences; memory contents need
//   no clearing and the block is ready as soon as reset is released.
`default_nettype none

module edit_script_run_stack_cost #(
    parameter int MAX_SEQ_LEN = esrsc_pkg::DEF_MAX_SEQ_LEN,
    parameter int MAX_RUNS    = esrsc_pkg::DEF_MAX_RUNS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire logic [esrsc_pkg::OP_W-1:0]  op,
    input  wire logic [esrsc_pkg::SYM_W-1:0] symbol,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output logic [esrsc_pkg::COST_W-1:0]     cost,
    output logic                             script_valid,
    output logic [esrsc_pkg::ERR_W-1:0]      error_code,
    output logic [esrsc_pkg::CNT_W-1:0]      run_count
);
    import esrsc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    esrsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    esrsc_dp #(
        .MAX_SEQ_LEN (MAX_SEQ_LEN),
        .MAX_RUNS    (MAX_RUNS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (op),
        .symbol       (symbol),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .cost         (cost),
        .script_valid (script_valid),
        .error_code   (error_code),
        .run_count    (run_count)
    );

endmodule

`default_nettype wire

// ===== design/esrsc_dp.sv =====
// Datapath: run stack and sequence memories, counters, accumulators, result register.
// Depends on esrsc_pkg; driven by esrsc_ctrl commands.
`default_nettype none

module esrsc_dp #(
    parameter int MAX_SEQ_LEN = esrsc_pkg::DEF_MAX_SEQ_LEN,
    parameter int MAX_RUNS    = esrsc_pkg::DEF_MAX_RUNS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire esrsc_pkg::dp_cmd_t         cmd,
    output esrsc_pkg::dp_stat_t             stat,
    input  wire logic [esrsc_pkg::OP_W-1:0] op,
    input  wire logic [esrsc_pkg::SYM_W-1:0] symbol,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output logic [esrsc_pkg::COST_W-1:0]    cost,
    output logic                            script_valid,
    output logic [esrsc_pkg::ERR_W-1:0]     error_code,
    output logic [esrsc_pkg::CNT_W-1:0]     run_count
);
    import esrsc_pkg::*;

    localparam int SA_W  = $clog2(MAX_SEQ_LEN);
    localparam int LEN_W = $clog2(MAX_SEQ_LEN + 1);
    localparam int RA_W  = $clog2(MAX_RUNS);
    localparam int RC_W  = $clog2(MAX_RUNS + 1);
    localparam int SUM_W = ((LEN_W > STEP_W) ? LEN_W : STEP_W) + 1;
    localparam int CMP_W = (RC_W > CNT_W) ? RC_W : CNT_W;

    logic [ENTRY_W-1:0] run_mem [MAX_RUNS];
    logic [SYM_W-1:0]   seq_u [MAX_SEQ_LEN];
    logic [SYM_W-1:0]   seq_v [MAX_SEQ_LEN];

    op_t                op_reg, op_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic [RC_W-1:0]    run_top_reg, run_top_next;
    logic [LEN_W-1:0]   u_len_reg, u_len_next;
    logic [LEN_W-1:0]   v_len_reg, v_len_next;
    logic [ENTRY_W-1:0] top_reg, top_next;
    logic [RC_W-1:0]    ptr_reg, ptr_next;
    logic [LEN_W-1:0]   u_acc_reg, u_acc_next;
    logic [LEN_W-1:0]   v_acc_reg, v_acc_next;
    logic               u_over_reg, u_over_next;
    logic               v_over_reg, v_over_next;
    logic [LEN_W-1:0]   uc_reg, uc_next;
    logic [LEN_W-1:0]   vc_reg, vc_next;
    logic [KIND_W-1:0]  cur_kind_reg, cur_kind_next;
    logic [STEP_W-1:0]  cur_left_reg, cur_left_next;
    logic [COST_W-1:0]  cost_reg, cost_next;
    logic               ok_reg, ok_next;
    err_t               err_reg, err_next;
    logic               sum_pend_reg, cmp_pend_reg;
    logic               res_valid_reg, res_valid_next;
    logic [COST_W-1:0]  res_cost_reg, res_cost_next;
    logic               res_ok_reg, res_ok_next;
    err_t               res_err_reg, res_err_next;
    logic [CNT_W-1:0]   res_cnt_reg, res_cnt_next;

    logic [ENTRY_W-1:0] run_rd_reg;
    logic [SYM_W-1:0]   su_rd_reg, sv_rd_reg;

    logic               run_we, run_re;
    logic [RA_W-1:0]    run_waddr, run_raddr;
    logic [ENTRY_W-1:0] run_wdata;
    logic               su_we, sv_we;

    logic [KIND_W-1:0]  top_kind, add_kind, rd_kind;
    logic [STEP_W-1:0]  top_steps, rd_steps;
    logic [RA_W-1:0]    top_idx;
    logic               same_kind;
    logic [SUM_W-1:0]   u_sum, v_sum;
    logic [COST_W:0]    cost_sum;
    logic [STEP_W-1:0]  cost_inc;

    assign top_kind  = top_reg[ENTRY_W-1:STEP_W];
    assign top_steps = top_reg[STEP_W-1:0];
    assign rd_kind   = run_rd_reg[ENTRY_W-1:STEP_W];
    assign rd_steps  = run_rd_reg[STEP_W-1:0];
    assign add_kind  = op_reg[KIND_W-1:0];
    assign top_idx   = RA_W'(run_top_reg - RC_W'(1));
    assign same_kind = (run_top_reg != '0) && (top_kind == add_kind);
    assign u_sum     = SUM_W'(u_acc_reg) + SUM_W'(rd_steps);
    assign v_sum     = SUM_W'(v_acc_reg) + SUM_W'(rd_steps);
    assign cost_inc  = cmd.indel ? cur_left_reg : STEP_W'(1);
    assign cost_sum  = (COST_W+1)'(cost_reg) + (COST_W+1)'(cost_inc);

    always_comb
    begin
        op_next        = op_reg;
        sym_next       = sym_reg;
        run_top_next   = run_top_reg;
        u_len_next     = u_len_reg;
        v_len_next     = v_len_reg;
        top_next       = top_reg;
        ptr_next       = ptr_reg;
        u_acc_next     = u_acc_reg;
        v_acc_next     = v_acc_reg;
        u_over_next    = u_over_reg;
        v_over_next    = v_over_reg;
        uc_next        = uc_reg;
        vc_next        = vc_reg;
        cur_kind_next  = cur_kind_reg;
        cur_left_next  = cur_left_reg;
        cost_next      = cost_reg;
        ok_next        = ok_reg;
        err_next       = err_reg;
        res_valid_next = res_valid_reg;
        res_cost_next  = res_cost_reg;
        res_ok_next    = res_ok_reg;
        res_err_next   = res_err_reg;
        res_cnt_next   = res_cnt_reg;
        run_we         = 1'b0;
        run_waddr      = top_idx;
        run_wdata      = top_reg;
        run_re         = 1'b0;
        run_raddr      = top_idx;
        su_we          = 1'b0;
        sv_we          = 1'b0;

        if (cmd.cap)
        begin
            op_next   = op_t'(op);
            sym_next  = symbol;
            err_next  = ERR_OK;
            cost_next = '0;
            ok_next   = 1'b0;
        end

        if (cmd.exec)
        begin
            case (op_reg)
                OP_ADD_REP, OP_ADD_DEL, OP_ADD_INS:
                begin
                    if (same_kind)
                    begin
                        if (top_steps == STEP_MAX)
                        begin
                            err_next = ERR_STEP_OVF;
                        end
                        else
                        begin
                            top_next  = {add_kind, top_steps + STEP_W'(1)};
                            run_we    = 1'b1;
                            run_wdata = top_next;
                        end
                    end
                    else if (run_top_reg == RC_W'(MAX_RUNS))
                    begin
                        err_next = ERR_RUNS_FULL;
                    end
                    else
                    begin
                        top_next     = {add_kind, STEP_W'(1)};
                        run_we       = 1'b1;
                        run_waddr    = RA_W'(run_top_reg);
                        run_wdata    = top_next;
                        run_top_next = run_top_reg + RC_W'(1);
                    end
                end
                OP_REMOVE:
                begin
                    if (run_top_reg == '0)
                    begin
                        err_next = ERR_EMPTY;
                    end
                    else if (top_steps <= STEP_W'(1))
                    begin
                        run_top_next = run_top_reg - RC_W'(1);
                    end
                    else
                    begin
                        top_next  = {top_kind, top_steps - STEP_W'(1)};
                        run_we    = 1'b1;
                        run_wdata = top_next;
                    end
                end
                OP_LOAD_U:
                begin
                    if (u_len_reg == LEN_W'(MAX_SEQ_LEN))
                    begin
                        err_next = ERR_SEQ_FULL;
                    end
                    else
                    begin
                        su_we      = 1'b1;
                        u_len_next = u_len_reg + LEN_W'(1);
                    end
                end
                OP_LOAD_V:
                begin
                    if (v_len_reg == LEN_W'(MAX_SEQ_LEN))
                    begin
                        err_next = ERR_SEQ_FULL;
                    end
                    else
                    begin
                        sv_we      = 1'b1;
                        v_len_next = v_len_reg + LEN_W'(1);
                    end
                end
                OP_CLEAR:
                begin
                    run_top_next = '0;
                    u_len_next   = '0;
                    v_len_next   = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.top_rd)
        begin
            run_re = 1'b1;
        end
        if (cmd.top_ld)
        begin
            top_next = run_rd_reg;
        end

        if (cmd.sum_init)
        begin
            ptr_next    = run_top_reg;
            u_acc_next  = '0;
            v_acc_next  = '0;
            u_over_next = 1'b0;
            v_over_next = 1'b0;
        end
        if (cmd.sum_rd || cmd.cost_rd)
        begin
            run_re    = 1'b1;
            run_raddr = RA_W'(ptr_reg - RC_W'(1));
            ptr_next  = ptr_reg - RC_W'(1);
        end
        if (sum_pend_reg)
        begin
            if ((rd_kind == KIND_REP || rd_kind == KIND_DEL) && !u_over_reg)
            begin
                if (u_sum > SUM_W'(u_len_reg))
                    u_over_next = 1'b1;
                else
                    u_acc_next = LEN_W'(u_sum);
            end
            if ((rd_kind == KIND_REP || rd_kind == KIND_INS) && !v_over_reg)
            begin
                if (v_sum > SUM_W'(v_len_reg))
                    v_over_next = 1'b1;
                else
                    v_acc_next = LEN_W'(v_sum);
            end
        end

        if (cmd.cost_init)
        begin
            ptr_next  = run_top_reg;
            uc_next   = '0;
            vc_next   = '0;
            cost_next = '0;
            ok_next   = 1'b1;
        end
        if (cmd.cur_ld)
        begin
            cur_kind_next = rd_kind;
            cur_left_next = rd_steps;
        end
        if (cmd.indel || (cmp_pend_reg && (su_rd_reg != sv_rd_reg)))
        begin
            cost_next = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
        end
        if (cmd.indel)
        begin
            if (cur_kind_reg == KIND_DEL)
                uc_next = uc_reg + LEN_W'(cur_left_reg);
            else
                vc_next = vc_reg + LEN_W'(cur_left_reg);
        end
        if (cmd.seq_rd)
        begin
            uc_next       = uc_reg + LEN_W'(1);
            vc_next       = vc_reg + LEN_W'(1);
            cur_left_next = cur_left_reg - STEP_W'(1);
        end

        if (cmd.res_load)
        begin
            res_valid_next = 1'b1;
            res_cost_next  = cost_reg;
            res_ok_next    = ok_reg;
            res_err_next   = err_reg;
            if (CMP_W'(run_top_reg) > CMP_W'(CNT_MAX))
                res_cnt_next = CNT_MAX;
            else
                res_cnt_next = CNT_W'(run_top_reg);
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_top_reg   <= '0;
            u_len_reg     <= '0;
            v_len_reg     <= '0;
            sum_pend_reg  <= 1'b0;
            cmp_pend_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            run_top_reg   <= run_top_next;
            u_len_reg     <= u_len_next;
            v_len_reg     <= v_len_next;
            sum_pend_reg  <= cmd.sum_rd;
            cmp_pend_reg  <= cmd.seq_rd;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        sym_reg      <= sym_next;
        top_reg      <= top_next;
        ptr_reg      <= ptr_next;
        u_acc_reg    <= u_acc_next;
        v_acc_reg    <= v_acc_next;
        u_over_reg   <= u_over_next;
        v_over_reg   <= v_over_next;
        uc_reg       <= uc_next;
        vc_reg       <= vc_next;
        cur_kind_reg <= cur_kind_next;
        cur_left_reg <= cur_left_next;
        cost_reg     <= cost_next;
        ok_reg       <= ok_next;
        err_reg      <= err_next;
        res_cost_reg <= res_cost_next;
        res_ok_reg   <= res_ok_next;
        res_err_reg  <= res_err_next;
        res_cnt_reg  <= res_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (run_we)
            run_mem[run_waddr] <= run_wdata;
        if (run_re)
            run_rd_reg <= run_mem[run_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (su_we)
            seq_u[SA_W'(u_len_reg)] <= sym_reg;
        if (cmd.seq_rd)
            su_rd_reg <= seq_u[SA_W'(uc_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (sv_we)
            seq_v[SA_W'(v_len_reg)] <= sym_reg;
        if (cmd.seq_rd)
            sv_rd_reg <= seq_v[SA_W'(vc_reg)];
    end

    assign stat.is_eval    = (op_reg == OP_EVAL);
    assign stat.pop_reload = (op_reg == OP_REMOVE) && (run_top_reg > RC_W'(1))
                             && (top_steps <= STEP_W'(1));
    assign stat.ptr_zero   = (ptr_reg == '0);
    assign stat.lens_ok    = !u_over_reg && !v_over_reg
                             && (u_acc_reg == u_len_reg) && (v_acc_reg == v_len_reg);
    assign stat.cur_rep    = (cur_kind_reg == KIND_REP);
    assign stat.left_zero  = (cur_left_reg == '0);
    assign stat.res_free   = !res_valid_reg || res_ready;

    assign res_valid    = res_valid_reg;
    assign cost         = res_cost_reg;
    assign script_valid = res_ok_reg;
    assign error_code   = res_err_reg;
    assign run_count    = res_cnt_reg;

endmodule

`default_nettype wire

// ===== design/esrsc_ctrl.sv =====
// Controller state machine: sequences edit, pop reload and evaluate walks.
// Depends on esrsc_pkg; commands esrsc_dp.
`default_nettype none

module esrsc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire esrsc_pkg::dp_stat_t stat,
    output esrsc_pkg::dp_cmd_t      cmd
);
    import esrsc_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (req_valid)
                    state_next = S_EXEC;
            S_EXEC:
                if (stat.is_eval)
                    state_next = S_SUM;
                else if (stat.pop_reload)
                    state_next = S_TOP_RD;
                else
                    state_next = S_DONE;
            S_TOP_RD:
                state_next = S_TOP_LD;
            S_TOP_LD:
                state_next = S_DONE;
            S_SUM:
                if (stat.ptr_zero)
                    state_next = S_CHECK;
            S_CHECK:
                state_next = stat.lens_ok ? S_COST_RD : S_DONE;
            S_COST_RD:
                state_next = stat.ptr_zero ? S_DONE : S_COST_LD;
            S_COST_LD:
                state_next = S_COST_STEP;
            S_COST_STEP:
                if (!stat.cur_rep || stat.left_zero)
                    state_next = S_COST_RD;
            S_DONE:
                if (stat.res_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.cap   = req_valid;
            end
            S_EXEC:
            begin
                cmd.sum_init = stat.is_eval;
                cmd.exec     = !stat.is_eval;
            end
            S_TOP_RD:
                cmd.top_rd = 1'b1;
            S_TOP_LD:
                cmd.top_ld = 1'b1;
            S_SUM:
                cmd.sum_rd = !stat.ptr_zero;
            S_CHECK:
                cmd.cost_init = stat.lens_ok;
            S_COST_RD:
                cmd.cost_rd = !stat.ptr_zero;
            S_COST_LD:
                cmd.cur_ld = 1'b1;
            S_COST_STEP:
            begin
                cmd.indel  = !stat.cur_rep;
                cmd.seq_rd = stat.cur_rep && !stat.left_zero;
            end
            S_DONE:
                cmd.res_load = stat.res_free;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== design/esrsc_checker.sv =====
// Port-level checks for edit_script_run_stack_cost, attached by bind.
// Depends on esrsc_pkg.
`default_nettype none

module esrsc_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        req_valid,
    input wire logic                        req_ready,
    input wire logic                        res_valid,
    input wire logic                        res_ready,
    input wire logic [esrsc_pkg::COST_W-1:0] cost,
    input wire logic                        script_valid,
    input wire logic [esrsc_pkg::ERR_W-1:0] error_code,
    input wire logic [esrsc_pkg::CNT_W-1:0] run_count
);
    import esrsc_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped before it was taken");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(cost) && $stable(script_valid)
                                    && $stable(error_code) && $stable(run_count))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one still in work");

    a_valid_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && script_valid |-> error_code == ERR_OK)
        else $error("valid script reported with an error code");

    a_cost_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !script_valid |-> cost == '0)
        else $error("nonzero cost without a valid script");

endmodule

bind edit_script_run_stack_cost esrsc_checker u_esrsc_checker (.*);

`default_nettype wire

// ===== tb/tb_edit_script_run_stack_cost.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for edit_script_run_stack_cost: directed edge cases,
// then random edit scripts.
// Depends on esrsc_pkg and the block's RTL only.

module tb_edit_script_run_stack_cost;
    import esrsc_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_REQS = 255;
    localparam int SHOWN_MAX   = 40;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              valid;
        err_t              err;
        logic [CNT_W-1:0]  count;
    } edit_result_t;

    // Mirror of the run stack and both sequences; holds the results still owed.
    class edit_cost_board;
        logic [KIND_W-1:0] run_kind  [DEF_MAX_RUNS];
        logic [STEP_W-1:0] run_steps [DEF_MAX_RUNS];
        logic [SYM_W-1:0]  seq_u     [DEF_MAX_SEQ_LEN];
        logic [SYM_W-1:0]  seq_v     [DEF_MAX_SEQ_LEN];
        int                run_top    = 0;
        int                u_len      = 0;
        int                v_len      = 0;
        int                mismatches = 0;
        int                checked    = 0;
        edit_result_t      awaited[$];

        task report(input string what, input logic [31:0] got, input logic [31:0] want);
            mismatches++;
            if (mismatches <= SHOWN_MAX)
                $display("mismatch on result %0d, %0s: got %0h, expected %0h",
                         checked, what, got, want);
        endtask

        function err_t add_step(input logic [KIND_W-1:0] kind);
            if (run_top > 0 && run_kind[run_top-1] == kind)
            begin
                if (run_steps[run_top-1] == STEP_MAX)
                    return ERR_STEP_OVF;
                run_steps[run_top-1]++;
                return ERR_OK;
            end
            if (run_top >= DEF_MAX_RUNS)
                return ERR_RUNS_FULL;
            run_kind[run_top]  = kind;
            run_steps[run_top] = 1;
            run_top++;
            return ERR_OK;
        endfunction

        function void unit_cost(output logic ok, output logic [COST_W-1:0] total_cost);
            int used_u, used_v, total, ui, vi, i, s;
            used_u = 0;
            used_v = 0;
            total  = 0;
            ui     = 0;
            vi     = 0;
            for (i = run_top - 1; i >= 0; i--)
            begin
                if (run_kind[i] != KIND_INS)
                    used_u += run_steps[i];
                if (run_kind[i] != KIND_DEL)
                    used_v += run_steps[i];
            end
            ok = (used_u == u_len) && (used_v == v_len);
            total_cost = '0;
            if (!ok)
                return;
            for (i = run_top - 1; i >= 0; i--)
                for (s = 0; s < run_steps[i]; s++)
                begin
                    if (run_kind[i] == KIND_REP)
                    begin
                        if (seq_u[ui] != seq_v[vi])
                            total++;
                        ui++;
                        vi++;
                    end
                    else if (run_kind[i] == KIND_DEL)
                    begin
                        total++;
                        ui++;
                    end
                    else
                    begin
                        total++;
                        vi++;
                    end
                end
            total_cost = (total > COST_MAX) ? COST_MAX : total[COST_W-1:0];
        endfunction

        function void note_request(input op_t code, input logic [SYM_W-1:0] sym);
            edit_result_t      r;
            logic              ok;
            logic [COST_W-1:0] c;
            r.cost  = '0;
            r.valid = 1'b0;
            r.err   = ERR_OK;
            case (code)
                OP_ADD_REP: r.err = add_step(KIND_REP);
                OP_ADD_DEL: r.err = add_step(KIND_DEL);
                OP_ADD_INS: r.err = add_step(KIND_INS);
                OP_REMOVE:
                begin
                    if (run_top == 0)
                        r.err = ERR_EMPTY;
                    else if (run_steps[run_top-1] <= 1)
                        run_top--;
                    else
                        run_steps[run_top-1]--;
                end
                OP_LOAD_U:
                begin
                    if (u_len >= DEF_MAX_SEQ_LEN)
                        r.err = ERR_SEQ_FULL;
                    else
                    begin
                        seq_u[u_len] = sym;
                        u_len++;
                    end
                end
                OP_LOAD_V:
                begin
                    if (v_len >= DEF_MAX_SEQ_LEN)
                        r.err = ERR_SEQ_FULL;
                    else
                    begin
                        seq_v[v_len] = sym;
                        v_len++;
                    end
                end
                OP_EVAL:
                begin
                    unit_cost(ok, c);
                    r.valid = ok;
                    r.cost  = c;
                end
                default:
                begin
                    run_top = 0;
                    u_len   = 0;
                    v_len   = 0;
                end
            endcase
            r.count = (run_top > CNT_MAX) ? CNT_MAX : run_top[CNT_W-1:0];
            awaited.push_back(r);
        endfunction

        task check_result(input logic [COST_W-1:0] c, input logic v,
                          input logic [ERR_W-1:0] e, input logic [CNT_W-1:0] n);
            edit_result_t w;
            if (awaited.size() == 0)
            begin
                report("result with no request outstanding", 0, 0);
                return;
            end
            w = awaited.pop_front();
            if (c !== w.cost)
                report("cost", c, w.cost);
            if (v !== w.valid)
                report("script_valid", v, w.valid);
            if (e !== w.err)
                report("error_code", e, w.err);
            if (n !== w.count)
                report("run_count", n, w.count);
            checked++;
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    logic [OP_W-1:0]    op;
    logic [SYM_W-1:0]   symbol;
    logic               res_valid;
    logic               res_ready;
    logic [COST_W-1:0]  cost;
    logic               script_valid;
    logic [ERR_W-1:0]   error_code;
    logic [CNT_W-1:0]   run_count;

    edit_cost_board     board;
    logic               idle_on = 1'b1;
    int                 n_sent  = 0;
    int unsigned        cycles  = 0;

    op_t dir_ops [25] = '{
        OP_REMOVE,  OP_EVAL,    OP_LOAD_U,  OP_LOAD_U,  OP_LOAD_U,
        OP_LOAD_V,  OP_LOAD_V,  OP_ADD_DEL, OP_ADD_REP, OP_ADD_REP,
        OP_EVAL,    OP_ADD_INS, OP_EVAL,    OP_REMOVE,  OP_REMOVE,
        OP_ADD_INS, OP_ADD_DEL, OP_EVAL,    OP_CLEAR,   OP_EVAL,
        OP_LOAD_V,  OP_ADD_INS, OP_EVAL,    OP_REMOVE,  OP_REMOVE
    };
    logic [SYM_W-1:0] dir_syms [25] = '{
        8'h00, 8'hFF, 8'h00, 8'hFF, 8'h5A,
        8'hFF, 8'h5A, 8'h00, 8'h00, 8'hFF,
        8'h00, 8'h00, 8'hFF, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'hFF, 8'h00,
        8'hA5, 8'h00, 8'h00, 8'h00, 8'h00
    };

    edit_script_run_stack_cost uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .op           (op),
        .symbol       (symbol),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .cost         (cost),
        .script_valid (script_valid),
        .error_code   (error_code),
        .run_count    (run_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, board.awaited.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side: check on handshake, stall at random
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_ready === 1'b1)
            board.check_result(cost, script_valid, error_code, run_count);
        res_ready <= !(idle_on && $urandom_range(0, 99) < 11);
    end

    function automatic logic [SYM_W-1:0] pick_symbol();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return SYM_W'($urandom_range(0, 3));
            default: return SYM_W'($urandom_range(0, 255));
        endcase
    endfunction

    // valid is left high after acceptance unless a gap follows
    task automatic send_request(input op_t code, input logic [SYM_W-1:0] sym);
        int gap;
        req_valid <= 1'b1;
        op        <= code;
        symbol    <= sym;
        do @(posedge clk); while (req_ready !== 1'b1);
        board.note_request(code, sym);
        n_sent++;
        gap = 0;
        if (idle_on)
            while ($urandom_range(0, 99) < 11)
                gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int  k, base, episode, u_need, v_need, u_got, v_got;
        op_t step_op;

        board     = new();
        rst_n     = 1'b0;
        req_valid = 1'b0;
        op        = OP_ADD_REP;
        symbol    = '0;
        res_ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < 25; k++)
            send_request(dir_ops[k], dir_syms[k]);
        wait_drained();

        base    = n_sent;
        episode = 0;
        while (n_sent - base < RANDOM_REQS)
        begin
            idle_on = !(episode >= 6 && episode < 12);
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    send_request(op_t'($urandom_range(0, 7)), SYM_W'($urandom_range(0, 255)));
                send_request(OP_EVAL, SYM_W'($urandom_range(0, 255)));
            end
            else
            begin
                send_request(OP_CLEAR, pick_symbol());
                if ($urandom_range(0, 9) == 0)
                begin
                    u_need = $urandom_range(0, 24);
                    v_need = $urandom_range(0, 24);
                end
                else
                begin
                    u_need = $urandom_range(0, 6);
                    v_need = $urandom_range(0, 6);
                end
                u_got = 0;
                v_got = 0;
                while (u_got < u_need || v_got < v_need)
                begin
                    if (v_got >= v_need || (u_got < u_need && $urandom_range(0, 1)))
                    begin
                        send_request(OP_LOAD_U, pick_symbol());
                        u_got++;
                    end
                    else
                    begin
                        send_request(OP_LOAD_V, pick_symbol());
                        v_got++;
                    end
                end
                u_got = 0;
                v_got = 0;
                while (u_got < u_need || v_got < v_need)
                begin
                    step_op = (u_got == u_need) ? OP_ADD_INS :
                              (v_got == v_need) ? OP_ADD_DEL : op_t'($urandom_range(0, 2));
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_request(op_t'($urandom_range(0, 2)), pick_symbol());
                        send_request(OP_REMOVE, pick_symbol());
                    end
                    send_request(step_op, pick_symbol());
                    if (step_op != OP_ADD_INS)
                        u_got++;
                    if (step_op != OP_ADD_DEL)
                        v_got++;
                    if ($urandom_range(0, 19) == 0)
                        send_request(OP_EVAL, pick_symbol());
                end
                // spoil the script now and then
                if ($urandom_range(0, 4) == 0)
                    send_request(op_t'($urandom_range(0, 3)), pick_symbol());
                send_request(OP_EVAL, pick_symbol());
            end
            if (episode == 9)
                wait_drained();
            episode++;
        end
        idle_on = 1'b1;

        wait_drained();
        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.awaited.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
